// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

   // word format
   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;

   // derived widths
   localparam int PROD_BITS  = 2 * WORD_BITS;          // full product / sum of squares
   localparam int SUM_BITS   = PROD_BITS + 1;          // signed sum of two products
   localparam int MAG_BITS   = PROD_BITS - FRAC_BITS;  // magnitude handed to the clip stage
   localparam int REM_BITS   = PROD_BITS + 2;          // partial remainder in a cell
   localparam int DIV_STEPS  = WORD_BITS;              // first row: quotient bits / root bits
   localparam int ROOT_STEPS = (WORD_BITS + FRAC_BITS + 2) / 2;  // second row of cells
   localparam int ROOT_FIELD = 2 * ROOT_STEPS;
   localparam int FRONT_STAGES = 5;
   localparam int LATENCY    = FRONT_STAGES + DIV_STEPS + 1 + ROOT_STEPS + 1;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_SCALE,
      OP_DIV,
      OP_CONJ,
      OP_SQRT,
      OP_MAG
   } op_type;

   // one digit-recurrence lane: remainder, developed bits, bits still to shift in
   typedef struct packed {
      logic [REM_BITS-1:0]  rem;
      logic [WORD_BITS-1:0] q;
      logic [PROD_BITS-1:0] src;
   } lane_type;

   // everything an item carries down the row of cells
   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic                 neg_re;
      logic                 neg_im;
      logic                 ovf_re;
      logic                 ovf_im;
      logic                 dz;
      logic [MAG_BITS-1:0]  mag_re;
      logic [MAG_BITS-1:0]  mag_im;
      logic [WORD_BITS-1:0] x;
      logic [PROD_BITS-1:0] dvs;
      lane_type             lane_a;
      lane_type             lane_b;
   } stage_type;

endpackage

// ===== hw/rtl/cau_front.sv =====
module cau_front import cau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2:0]                  opcode,
   input  logic signed [WORD_BITS-1:0] a_re,
   input  logic signed [WORD_BITS-1:0] a_im,
   input  logic signed [WORD_BITS-1:0] b_re,
   input  logic signed [WORD_BITS-1:0] b_im,
   output stage_type                   entry
);

   // stage 1: operand capture
   logic                        v1_ff;
   op_type                      op1_ff;
   logic signed [WORD_BITS-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // stage 2: products
   logic                        v2_ff;
   op_type                      op2_ff;
   logic signed [WORD_BITS-1:0] ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_BITS-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic signed [WORD_BITS-1:0] mul_a, mul_b;
   logic                        squares;

   // stage 3: sums
   logic                        v3_ff;
   op_type                      op3_ff;
   logic signed [SUM_BITS-1:0]  re3_ff, im3_ff, re3_in, im3_in;
   logic [PROD_BITS-1:0]        d3_ff, d3_in;
   logic [WORD_BITS-1:0]        x3_ff;
   logic                        yneg3_ff;

   // stage 4: sign and magnitude
   logic                        v4_ff;
   op_type                      op4_ff;
   logic                        nre4_ff, nim4_ff;
   logic [PROD_BITS-1:0]        mre4_ff, mim4_ff, mre4_in, mim4_in;
   logic signed [SUM_BITS-1:0]  abs_re, abs_im;
   logic [PROD_BITS-1:0]        d4_ff;
   logic                        dz4_ff;
   logic [WORD_BITS-1:0]        x4_ff;
   logic                        yneg4_ff;

   // stage 5: row entry
   stage_type                   entry_ff, entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      op1_ff <= op_type'(opcode);
      ar1_ff <= a_re;
      ai1_ff <= a_im;
      br1_ff <= b_re;
      bi1_ff <= b_im;
   end

   always_comb begin
      squares = (op1_ff == OP_SQRT) || (op1_ff == OP_MAG);
      mul_a   = squares ? ar1_ff : br1_ff;
      mul_b   = squares ? ai1_ff : bi1_ff;
      p0_in   = PROD_BITS'(ar1_ff) * PROD_BITS'(mul_a);
      p1_in   = PROD_BITS'(ai1_ff) * PROD_BITS'(mul_b);
      p2_in   = PROD_BITS'(ar1_ff) * PROD_BITS'(bi1_ff);
      p3_in   = PROD_BITS'(ai1_ff) * PROD_BITS'(br1_ff);
      p4_in   = PROD_BITS'(br1_ff) * PROD_BITS'(br1_ff);
      p5_in   = PROD_BITS'(bi1_ff) * PROD_BITS'(bi1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      op2_ff <= op1_ff;
      ar2_ff <= ar1_ff;
      ai2_ff <= ai1_ff;
      br2_ff <= br1_ff;
      bi2_ff <= bi1_ff;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      p3_ff  <= p3_in;
      p4_ff  <= p4_in;
      p5_ff  <= p5_in;
   end

   always_comb begin
      unique case (op2_ff)
         OP_ADD: begin
            re3_in = SUM_BITS'(ar2_ff) + SUM_BITS'(br2_ff);
            im3_in = SUM_BITS'(ai2_ff) + SUM_BITS'(bi2_ff);
         end
         OP_SUB: begin
            re3_in = SUM_BITS'(ar2_ff) - SUM_BITS'(br2_ff);
            im3_in = SUM_BITS'(ai2_ff) - SUM_BITS'(bi2_ff);
         end
         OP_MUL: begin
            re3_in = SUM_BITS'(p0_ff) - SUM_BITS'(p1_ff);
            im3_in = SUM_BITS'(p2_ff) + SUM_BITS'(p3_ff);
         end
         OP_SCALE: begin
            re3_in = SUM_BITS'(p0_ff);
            im3_in = SUM_BITS'(p3_ff);
         end
         OP_DIV: begin
            re3_in = SUM_BITS'(p0_ff) + SUM_BITS'(p1_ff);
            im3_in = SUM_BITS'(p3_ff) - SUM_BITS'(p2_ff);
         end
         OP_CONJ: begin
            re3_in = SUM_BITS'(ar2_ff);
            im3_in = -SUM_BITS'(ai2_ff);
         end
         OP_SQRT, OP_MAG: begin
            re3_in = SUM_BITS'(p0_ff) + SUM_BITS'(p1_ff);
            im3_in = '0;
         end
         default: begin
            re3_in = '0;
            im3_in = '0;
         end
      endcase
      // both squares are non-negative, so the sum fits unsigned
      d3_in = $unsigned(p4_ff) + $unsigned(p5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      op3_ff   <= op2_ff;
      re3_ff   <= re3_in;
      im3_ff   <= im3_in;
      d3_ff    <= d3_in;
      x3_ff    <= ar2_ff;
      yneg3_ff <= ai2_ff[WORD_BITS-1];
   end

   always_comb begin
      abs_re  = re3_ff[SUM_BITS-1] ? -re3_ff : re3_ff;
      abs_im  = im3_ff[SUM_BITS-1] ? -im3_ff : im3_ff;
      mre4_in = abs_re[PROD_BITS-1:0];
      mim4_in = abs_im[PROD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      op4_ff   <= op3_ff;
      nre4_ff  <= re3_ff[SUM_BITS-1];
      nim4_ff  <= im3_ff[SUM_BITS-1];
      mre4_ff  <= mre4_in;
      mim4_ff  <= mim4_in;
      d4_ff    <= d3_ff;
      dz4_ff   <= (d3_ff == '0);
      x4_ff    <= x3_ff;
      yneg4_ff <= yneg3_ff;
   end

   always_comb begin
      entry_in        = '0;
      entry_in.valid  = v4_ff & ~reset;
      entry_in.op     = op4_ff;
      entry_in.neg_re = nre4_ff;
      entry_in.neg_im = nim4_ff;
      entry_in.dz     = dz4_ff;
      entry_in.x      = x4_ff;
      entry_in.dvs    = d4_ff;
      // quotient of at least 2^WORD_BITS always clips
      entry_in.ovf_re = {{FRAC_BITS{1'b0}}, mre4_ff} >= {d4_ff, {FRAC_BITS{1'b0}}};
      entry_in.ovf_im = {{FRAC_BITS{1'b0}}, mim4_ff} >= {d4_ff, {FRAC_BITS{1'b0}}};
      if ((op4_ff == OP_MUL) || (op4_ff == OP_SCALE)) begin
         entry_in.mag_re = mre4_ff[PROD_BITS-1:FRAC_BITS];
         entry_in.mag_im = mim4_ff[PROD_BITS-1:FRAC_BITS];
      end else begin
         entry_in.mag_re = mre4_ff[MAG_BITS-1:0];
         entry_in.mag_im = mim4_ff[MAG_BITS-1:0];
      end
      if (op4_ff == OP_DIV) begin
         // high part of the scaled dividend starts as remainder, low part shifts in
         entry_in.lane_a.rem = REM_BITS'(mre4_ff[PROD_BITS-1:FRAC_BITS]);
         entry_in.lane_a.src = {mre4_ff[FRAC_BITS-1:0], {(PROD_BITS-FRAC_BITS){1'b0}}};
         entry_in.lane_b.rem = REM_BITS'(mim4_ff[PROD_BITS-1:FRAC_BITS]);
         entry_in.lane_b.src = {mim4_ff[FRAC_BITS-1:0], {(PROD_BITS-FRAC_BITS){1'b0}}};
      end else if ((op4_ff == OP_SQRT) || (op4_ff == OP_MAG)) begin
         entry_in.lane_a.src = mre4_ff;
         entry_in.neg_re     = 1'b0;
         entry_in.neg_im     = yneg4_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/cau_cell.sv =====
module cau_cell import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      second,
   input  stage_type prev_stage,
   output stage_type next_stage
);

   stage_type stage_ff, stage_in;
   logic      root_mode;
   logic      active;

   // one restoring step: divide by dvs, or one root bit from two source bits
   function automatic lane_type lane_step(lane_type l, logic sq, logic [PROD_BITS-1:0] dvs);
      logic [REM_BITS-1:0] shifted;
      logic [REM_BITS-1:0] trial;
      logic [REM_BITS:0]   diff;
      lane_type            r;
      if (sq) begin
         shifted = {l.rem[REM_BITS-3:0], l.src[PROD_BITS-1:PROD_BITS-2]};
         trial   = {{(REM_BITS-WORD_BITS-2){1'b0}}, l.q, 2'b01};
         r.src   = {l.src[PROD_BITS-3:0], 2'b00};
      end else begin
         shifted = {l.rem[REM_BITS-2:0], l.src[PROD_BITS-1]};
         trial   = {{(REM_BITS-PROD_BITS){1'b0}}, dvs};
         r.src   = {l.src[PROD_BITS-2:0], 1'b0};
      end
      diff  = {1'b0, shifted} - {1'b0, trial};
      r.rem = diff[REM_BITS] ? shifted : diff[REM_BITS-1:0];
      r.q   = {l.q[WORD_BITS-2:0], ~diff[REM_BITS]};
      return r;
   endfunction

   always_comb begin
      root_mode = (prev_stage.op == OP_SQRT) || (prev_stage.op == OP_MAG);
      active    = !second || (prev_stage.op == OP_SQRT);
      stage_in  = prev_stage;
      stage_in.valid = prev_stage.valid & ~reset;
      if (active) begin
         stage_in.lane_a = lane_step(prev_stage.lane_a, root_mode, prev_stage.dvs);
         stage_in.lane_b = lane_step(prev_stage.lane_b, root_mode, prev_stage.dvs);
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next_stage = stage_ff;

endmodule

// ===== hw/rtl/cau_mid.sv =====
module cau_mid import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type prev_stage,
   output stage_type next_stage
);

   stage_type              stage_ff, stage_in;
   logic [WORD_BITS+1:0]   m_ext, x_ext, sum_a, sum_b;
   logic [ROOT_FIELD-1:0]  field_a, field_b;

   always_comb begin
      m_ext   = {2'b00, prev_stage.lane_a.q};
      x_ext   = {{2{prev_stage.x[WORD_BITS-1]}}, prev_stage.x};
      sum_a   = m_ext + x_ext;
      sum_b   = m_ext - x_ext;
      field_a = ROOT_FIELD'({sum_a, {(FRAC_BITS-1){1'b0}}});
      field_b = ROOT_FIELD'({sum_b, {(FRAC_BITS-1){1'b0}}});
      stage_in = prev_stage;
      stage_in.valid = prev_stage.valid & ~reset;
      if (prev_stage.op == OP_SQRT) begin
         stage_in.lane_a.rem = '0;
         stage_in.lane_a.q   = '0;
         stage_in.lane_a.src = {field_a, {(PROD_BITS-ROOT_FIELD){1'b0}}};
         stage_in.lane_b.rem = '0;
         stage_in.lane_b.q   = '0;
         stage_in.lane_b.src = {field_b, {(PROD_BITS-ROOT_FIELD){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next_stage = stage_ff;

endmodule

// ===== hw/rtl/cau_out.sv =====
module cau_out import cau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  stage_type            fin,
   output logic                 valid,
   output logic [WORD_BITS-1:0] res_re,
   output logic [WORD_BITS-1:0] res_im,
   output logic                 saturated,
   output logic                 div_zero
);

   logic                 valid_ff, sat_ff, dz_ff;
   logic [WORD_BITS-1:0] re_ff, im_ff;
   logic [MAG_BITS-1:0]  mre, mim;
   logic                 nre, nim;
   logic [WORD_BITS:0]   cre, cim;

   // clip a sign-magnitude value to the word range, flag in the top bit
   function automatic logic [WORD_BITS:0] clip(logic neg, logic [MAG_BITS-1:0] mag);
      logic [MAG_BITS-1:0]  lim;
      logic [MAG_BITS-1:0]  m;
      logic [WORD_BITS-1:0] low;
      logic                 s;
      lim = MAG_BITS'(1) << (WORD_BITS - 1);
      if (!neg) begin
         lim = lim - MAG_BITS'(1);
      end
      if (mag > lim) begin
         m = lim;
         s = 1'b1;
      end else begin
         m = mag;
         s = 1'b0;
      end
      low = m[WORD_BITS-1:0];
      return {s, neg ? -low : low};
   endfunction

   always_comb begin
      unique case (fin.op)
         OP_DIV: begin
            if (fin.dz) begin
               mre = '0;
               mim = '0;
               nre = 1'b0;
               nim = 1'b0;
            end else begin
               mre = fin.ovf_re ? '1 : MAG_BITS'(fin.lane_a.q);
               mim = fin.ovf_im ? '1 : MAG_BITS'(fin.lane_b.q);
               nre = fin.neg_re;
               nim = fin.neg_im;
            end
         end
         OP_MAG: begin
            mre = MAG_BITS'(fin.lane_a.q);
            mim = '0;
            nre = 1'b0;
            nim = 1'b0;
         end
         OP_SQRT: begin
            mre = MAG_BITS'(fin.lane_a.q);
            mim = MAG_BITS'(fin.lane_b.q);
            nre = 1'b0;
            nim = fin.neg_im;
         end
         default: begin
            mre = fin.mag_re;
            mim = fin.mag_im;
            nre = fin.neg_re;
            nim = fin.neg_im;
         end
      endcase
      cre = clip(nre, mre);
      cim = clip(nim, mim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sat_ff   <= 1'b0;
         dz_ff    <= 1'b0;
      end else begin
         valid_ff <= fin.valid;
         sat_ff   <= fin.valid & (cre[WORD_BITS] | cim[WORD_BITS]);
         dz_ff    <= fin.valid & fin.dz & (fin.op == OP_DIV);
      end
      re_ff <= cre[WORD_BITS-1:0];
      im_ff <= cim[WORD_BITS-1:0];
   end

   assign valid     = valid_ff;
   assign res_re    = re_ff;
   assign res_im    = im_ff;
   assign saturated = sat_ff;
   assign div_zero  = dz_ff;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// channel   ports                                   direction  timing
// request   start, busy, req_opcode, req_a_*, req_b_*  in      taken when start && !busy
// response  rsp_valid, rsp_res_*, rsp_saturated, ...   out     one-cycle strobe, no stall
//
// fully pipelined: one item per clock
// the bulk of the pipe is the row of digit cells: 32 divide/root cells, then 25 root cells
// busy is always low since the response side never stalls
// synchronous reset clears all valid bits; payload is left as is
// each op goes through the whole row so results leave in request order
module complex_arithmetic_unit import cau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_opcode,
   input  logic signed [WORD_BITS-1:0] req_a_re,
   input  logic signed [WORD_BITS-1:0] req_a_im,
   input  logic signed [WORD_BITS-1:0] req_b_re,
   input  logic signed [WORD_BITS-1:0] req_b_im,
   output logic                        rsp_valid,
   output logic signed [WORD_BITS-1:0] rsp_res_re,
   output logic signed [WORD_BITS-1:0] rsp_res_im,
   output logic                        rsp_saturated,
   output logic                        rsp_div_zero
);

   // first row: one quotient bit (two lanes) or one root bit per cell
   stage_type row_a [0:DIV_STEPS];
   // second row: principal root halves, only sqrt items are worked on
   stage_type row_b [0:ROOT_STEPS];
   logic      accept;

   // nothing ever holds the pipe
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // products, sums, magnitudes and dividend setup
   cau_front u_front (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .opcode (req_opcode),
      .a_re   (req_a_re),
      .a_im   (req_a_im),
      .b_re   (req_b_re),
      .b_im   (req_b_im),
      .entry  (row_a[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_row_a
      cau_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .second     (1'b0),
         .prev_stage (row_a[i]),
         .next_stage (row_a[i+1])
      );
   end

   // (|a| +- re(a)) scaled, ready for the second root
   cau_mid u_mid (
      .clock      (clock),
      .reset      (reset),
      .prev_stage (row_a[DIV_STEPS]),
      .next_stage (row_b[0])
   );

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_row_b
      cau_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .second     (1'b1),
         .prev_stage (row_b[j]),
         .next_stage (row_b[j+1])
      );
   end

   // result select, clipping and output register
   cau_out u_out (
      .clock     (clock),
      .reset     (reset),
      .fin       (row_b[ROOT_STEPS]),
      .valid     (rsp_valid),
      .res_re    (rsp_res_re),
      .res_im    (rsp_res_im),
      .saturated (rsp_saturated),
      .div_zero  (rsp_div_zero)
   );

endmodule

// ===== hw/rtl/cau_check.sv =====
module cau_check import cau_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [WORD_BITS-1:0] rsp_res_re,
   input logic [WORD_BITS-1:0] rsp_res_im,
   input logic                 rsp_saturated,
   input logic                 rsp_div_zero
);

   a_item_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching item");

   a_flags_with_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_saturated || rsp_div_zero) |-> rsp_valid)
      else $error("flag raised outside a result");

   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_div_zero |-> (rsp_res_re == '0) && (rsp_res_im == '0) && !rsp_saturated)
      else $error("divide by zero result not clean");

endmodule

bind complex_arithmetic_unit cau_check u_cau_check (.*);

// ===== tb/complex_arithmetic_unit_tb.sv =====
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   // wide signed type for exact intermediate products and quotients
   typedef logic signed [199:0] wide_type;

   typedef struct {
      op_type            op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
      bit                hold_drain;   // wait for all results before offering this item
   } cmd_type;

   typedef struct {
      logic signed [31:0] re, im;
      bit                sat, dz;
   } cplx_result_type;

   localparam wide_type WORD_MAX = (wide_type'(1) <<< (WORD_BITS - 1)) - 1;
   localparam wide_type WORD_MIN = -(wide_type'(1) <<< (WORD_BITS - 1));
   localparam int       STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_opcode = '0;
   logic signed [WORD_BITS-1:0] req_a_re = '0, req_a_im = '0;
   logic signed [WORD_BITS-1:0] req_b_re = '0, req_b_im = '0;
   logic rsp_valid;
   logic signed [WORD_BITS-1:0] rsp_res_re, rsp_res_im;
   logic rsp_saturated, rsp_div_zero;

   cmd_type         cmd_queue[$];
   cplx_result_type result_queue[$];
   int              mismatches = 0;
   int              items_taken = 0;
   int              quiet_cycles = 0;
   bit              stimulus_done = 1'b0;

   complex_arithmetic_unit DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor of the square root, bit by bit
   function automatic wide_type int_sqrt(input wide_type n);
      logic [199:0] r, c;
      r = '0;
      for (int k = 99; k >= 0; k--) begin
         c = r | (200'd1 << k);
         if (c * c <= n) r = c;
      end
      return wide_type'(r);
   endfunction

   function automatic logic signed [31:0] clip_word(input wide_type v, output bit clipped);
      clipped = 1'b0;
      if (v > WORD_MAX) begin
         clipped = 1'b1;
         return WORD_MAX[31:0];
      end
      if (v < WORD_MIN) begin
         clipped = 1'b1;
         return WORD_MIN[31:0];
      end
      return v[31:0];
   endfunction

   // exact complex result, truncated toward zero, then clipped per part
   function automatic cplx_result_type complex_result(input cmd_type c);
      wide_type x, y, u, v, re, im, d, m;
      bit f_re, f_im;
      cplx_result_type r;
      x = c.a_re; y = c.a_im; u = c.b_re; v = c.b_im;
      re = 0; im = 0; r.dz = 1'b0;
      case (c.op)
         OP_ADD:   begin re = x + u; im = y + v; end
         OP_SUB:   begin re = x - u; im = y - v; end
         OP_MUL:   begin re = (x * u - y * v) / 65536; im = (x * v + y * u) / 65536; end
         OP_SCALE: begin re = (x * u) / 65536; im = (y * u) / 65536; end
         OP_DIV: begin
            d = u * u + v * v;
            if (d == 0) r.dz = 1'b1;
            else begin
               re = ((x * u + y * v) * 65536) / d;
               im = ((y * u - x * v) * 65536) / d;
            end
         end
         OP_CONJ:  begin re = x; im = -y; end
         OP_SQRT: begin
            m  = int_sqrt(x * x + y * y);
            re = int_sqrt((m + x) * 32768);
            im = int_sqrt((m - x) * 32768);
            if (y < 0) im = -im;
         end
         default:  begin re = int_sqrt(x * x + y * y); im = 0; end
      endcase
      r.re  = clip_word(re, f_re);
      r.im  = clip_word(im, f_im);
      r.sat = f_re | f_im;
      return r;
   endfunction

   // mix of full-range, small, near-unity and extreme operand values
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $signed($urandom_range(2 ** 21)) - 2 ** 20;
         6:          return $signed($urandom_range(2 ** 27)) - 2 ** 26;
         7:          return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         8:          return $urandom_range(3) == 0 ? 0 : ($urandom_range(1) ? 65536 : -65536);
         default:    return $signed($urandom_range(64)) - 32;
      endcase
   endfunction

   task automatic add_cmd(input op_type op, input logic signed [31:0] ar, ai, br, bi,
                          input bit hold = 1'b0);
      cmd_type c;
      c.op = op; c.a_re = ar; c.a_im = ai; c.b_re = br; c.b_im = bi;
      c.hold_drain = hold;
      cmd_queue.push_back(c);
   endtask

   // item list: directed corners first, then random items
   initial begin
      cmd_type c;
      add_cmd(OP_ADD,   32'sh7fff_ffff, 32'sh8000_0000, 1, -1);          // both parts clip
      add_cmd(OP_SUB,   0, 0, 32'sh8000_0000, 32'sh8000_0000);           // negate most negative
      add_cmd(OP_SUB,   32'sh8000_0000, 32'sh7fff_ffff, 1, -1);
      add_cmd(OP_MUL,   32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      add_cmd(OP_MUL,   -98304, 65536, 131072, -32768);
      add_cmd(OP_SCALE, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0);
      add_cmd(OP_SCALE, -3, 5, 32768, 7);
      add_cmd(OP_DIV,   65536, 65536, 0, 0);                             // divide by zero
      add_cmd(OP_DIV,   32'sh7fff_ffff, 32'sh8000_0000, 1, 0);
      add_cmd(OP_DIV,   -196608, 65536, 65536, -131072);
      add_cmd(OP_DIV,   1, -1, 32'sh8000_0000, 32'sh8000_0000);
      add_cmd(OP_CONJ,  5, 32'sh8000_0000, 0, 0);                        // conj of most negative
      add_cmd(OP_CONJ,  32'sh8000_0000, 32'sh7fff_ffff, 9, 9);
      add_cmd(OP_SQRT,  0, 0, 0, 0);                                     // zero root
      add_cmd(OP_SQRT,  -262144, 0, 0, 0);                               // negative real input
      add_cmd(OP_SQRT,  32'sh8000_0000, 32'sh8000_0000, 0, 0);
      add_cmd(OP_SQRT,  32'sh7fff_ffff, -65536, 0, 0);
      add_cmd(OP_SQRT,  -1, 1, 0, 0);
      add_cmd(OP_MAG,   32'sh8000_0000, 32'sh8000_0000, 0, 0);           // magnitude clips
      add_cmd(OP_MAG,   196608, -262144, 3, 3);
      add_cmd(OP_MAG,   0, 0, -1, -1);
      for (int i = 0; i < 1650; i++) begin
         c.op   = op_type'($urandom_range(7));
         c.a_re = pick_word();
         c.a_im = pick_word();
         c.b_re = pick_word();
         c.b_im = pick_word();
         if ($urandom_range(15) == 0) c.b_im = 0;
         c.hold_drain = (i == 800 || i == 1400);
         cmd_queue.push_back(c);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: offer the next item, idle at random outside the no-idle stretch
   always @(posedge clock) begin
      cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            c.op = op_type'(req_opcode);
            c.a_re = req_a_re; c.a_im = req_a_im; c.b_re = req_b_re; c.b_im = req_b_im;
            result_queue.push_back(complex_result(c));
            items_taken++;
         end
         if (start && busy) begin
            // keep offering the same item until taken
         end else if (cmd_queue.size() == 0) begin
            start <= 1'b0;
            stimulus_done <= 1'b1;
         end else if (cmd_queue[0].hold_drain && (result_queue.size() != 0 || start)) begin
            start <= 1'b0;
         end else if ((items_taken < 500 || items_taken > 900) && $urandom_range(99) < 21) begin
            start <= 1'b0;
         end else begin
            c = cmd_queue.pop_front();
            start      <= 1'b1;
            req_opcode <= c.op;
            req_a_re   <= c.a_re;
            req_a_im   <= c.a_im;
            req_b_re   <= c.b_re;
            req_b_im   <= c.b_im;
         end
      end
   end

   // monitor: each strobe is checked against the oldest expectation
   always @(posedge clock) begin
      cplx_result_type e;
      if (!reset && rsp_valid) begin
         if (result_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result re=%0d im=%0d", rsp_res_re, rsp_res_im);
         end else begin
            e = result_queue.pop_front();
            if (rsp_res_re !== e.re || rsp_res_im !== e.im ||
                rsp_saturated !== e.sat || rsp_div_zero !== e.dz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp re=%0d im=%0d sat=%0b dz=%0b",
                           e.re, e.im, e.sat, e.dz,
                           " got re=%0d im=%0d sat=%0b dz=%0b",
                           rsp_res_re, rsp_res_im, rsp_saturated, rsp_div_zero);
            end
         end
      end
   end

   // watchdog: too long with neither an item taken nor a result seen
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // end of run: stimulus done, nothing outstanding, then a tail for stray results
   initial begin
      wait (stimulus_done && !start && result_queue.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && result_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
